@@ design/i2cbc_pkg.sv @@
`timescale 1ns / 1ps

package i2cbc_pkg;

  // Configuration register indexes.
  localparam logic CfgHalfPeriod = 1'b0;
  localparam logic CfgMaxPulses  = 1'b1;

  localparam int unsigned HalfPeriodWidth = 16;
  localparam int unsigned PulseWidth      = 4;
  localparam int unsigned CfgDataWidth    = 16;

  // Register values after reset.
  localparam logic [HalfPeriodWidth-1:0] HalfPeriodReset = 16'd10;
  localparam logic [PulseWidth-1:0]      MaxPulsesReset  = 4'd9;

  typedef struct packed {
    logic action;
    logic sda_level;
  } in_item_t;

  typedef struct packed {
    logic                  scl_release;
    logic                  sda_release;
    logic                  busy_res;
    logic                  finished;
    logic                  was_stuck;
    logic [PulseWidth-1:0] pulses_done;
    logic                  sda_free_at_end;
  } out_item_t;

endpackage

@@ design/i2cbc_core.sv @@
`timescale 1ns / 1ps

module i2cbc_core
  import i2cbc_pkg::*;
#(
  parameter int unsigned DelayWidth = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  in_item_t                   item_i,
  input  logic [HalfPeriodWidth-1:0] half_period_i,
  input  logic [PulseWidth-1:0]      max_pulses_i,
  output out_item_t                  result_o
);

  typedef enum logic [2:0] {
    PhIdle,
    PhRelease,
    PhLow,
    PhHigh,
    PhStop1,
    PhStop2,
    PhStop3,
    PhStop4
  } phase_e;

  localparam logic [PulseWidth-1:0] PulseMax = '1;

  phase_e                phase_q, phase_d;
  logic [DelayWidth-1:0] delay_q, delay_d;
  logic [PulseWidth-1:0] pulse_q, pulse_d;
  logic                  stuck_q, stuck_d;
  logic                  end_level_q, end_level_d;

  logic                  hold_ovf;
  logic [DelayWidth-1:0] hold;
  logic [DelayWidth-1:0] delay_inc;
  logic                  fin;
  logic                  scl_drv, sda_drv;
  logic [PulseWidth-1:0] pulse_inc;

  // Hold time: zero counts as one tick, a value beyond the counter saturates.
  assign hold_ovf  = |(half_period_i >> DelayWidth);
  assign hold      = hold_ovf ? '1 :
                     (half_period_i == '0) ? DelayWidth'(1) : DelayWidth'(half_period_i);
  assign delay_inc = delay_q + DelayWidth'(1);
  assign pulse_inc = (pulse_q == PulseMax) ? pulse_q : pulse_q + PulseWidth'(1);

  always_comb begin
    phase_d     = phase_q;
    delay_d     = delay_q;
    pulse_d     = pulse_q;
    stuck_d     = stuck_q;
    end_level_d = end_level_q;
    fin         = 1'b0;
    if (phase_q == PhIdle) begin
      if (item_i.action) begin
        phase_d = PhRelease;
        delay_d = '0;
        pulse_d = '0;
        stuck_d = 1'b0;
      end
    end else if (delay_inc < hold) begin
      delay_d = delay_inc;
    end else begin
      delay_d = '0;
      case (phase_q)
        PhRelease: begin
          if (item_i.sda_level) begin
            end_level_d = 1'b1;
            phase_d     = PhIdle;
            fin         = 1'b1;
          end else begin
            stuck_d = 1'b1;
            if (max_pulses_i != '0) begin
              phase_d = PhLow;
              pulse_d = pulse_inc;
            end else begin
              phase_d = PhStop1;
            end
          end
        end
        PhLow: phase_d = PhHigh;
        PhHigh: begin
          if (pulse_q < max_pulses_i && !item_i.sda_level) begin
            phase_d = PhLow;
            pulse_d = pulse_inc;
          end else begin
            phase_d = PhStop1;
          end
        end
        PhStop1: phase_d = PhStop2;
        PhStop2: phase_d = PhStop3;
        PhStop3: phase_d = PhStop4;
        default: begin
          end_level_d = item_i.sda_level;
          phase_d     = PhIdle;
          fin         = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    case (phase_d)
      PhLow: begin
        scl_drv = 1'b0;
        sda_drv = 1'b1;
      end
      PhStop1: begin
        scl_drv = 1'b0;
        sda_drv = 1'b1;
      end
      PhStop2: begin
        scl_drv = 1'b0;
        sda_drv = 1'b0;
      end
      PhStop3: begin
        scl_drv = 1'b1;
        sda_drv = 1'b0;
      end
      default: begin
        scl_drv = 1'b1;
        sda_drv = 1'b1;
      end
    endcase
  end

  always_comb begin
    result_o.scl_release     = scl_drv;
    result_o.sda_release     = sda_drv;
    result_o.busy_res        = (phase_d != PhIdle);
    result_o.finished        = fin;
    result_o.was_stuck       = stuck_d;
    result_o.pulses_done     = pulse_d;
    result_o.sda_free_at_end = end_level_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      delay_q     <= '0;
      pulse_q     <= '0;
      stuck_q     <= 1'b0;
      end_level_q <= 1'b1;
    end else if (step_i) begin
      phase_q     <= phase_d;
      delay_q     <= delay_d;
      pulse_q     <= pulse_d;
      stuck_q     <= stuck_d;
      end_level_q <= end_level_d;
    end
  end

endmodule

@@ design/i2cbc_out_buf.sv @@
`timescale 1ns / 1ps

module i2cbc_out_buf
  import i2cbc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  out_item_t in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      out_valid_q, skid_valid_q;
  out_item_t out_q, skid_q;
  logic      take, acc;

  // The skid entry catches an item that arrives while the output is held.
  assign in_stall_o  = skid_valid_q;
  assign take        = out_valid_q & ~out_stall_i;
  assign acc         = in_valid_i & ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= acc;
      end
    end else if (acc) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (acc) begin
        out_q <= in_item_i;
      end
    end else if (acc) begin
      if (out_valid_q) begin
        skid_q <= in_item_i;
      end else begin
        out_q <= in_item_i;
      end
    end
  end

endmodule

@@ design/i2c_bus_clear_sequencer.sv @@
`timescale 1ns / 1ps

// I2C bus-clear sequencer. Each input item is one time tick carrying a start
// command flag and the sampled SDA level; each accepted item yields exactly one
// result item with the SCL and SDA drives, busy and finished flags and the
// status of the current or last sequence. A start releases both lines for one
// half period; a free SDA then ends it, else SCL is clocked while SDA stays
// low (up to max_pulses pulses), closing with a STOP condition. The block takes
// one item per clock cycle while in_stall_o is low; the sequencer state updates
// in the cycle an item is accepted and its result is written to an output
// register, backed by a one-entry skid buffer, so a new item is accepted even
// while the previous result is still held by the sink. Configuration registers
// must only be written while no sequence is running and no results are pending.
module i2c_bus_clear_sequencer
  import i2cbc_pkg::*;
#(
  parameter int unsigned DelayWidth = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_item_t                in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_item_t               out_item_o
);

  logic [HalfPeriodWidth-1:0] half_period_q;
  logic [PulseWidth-1:0]      max_pulses_q;
  logic                       step;
  out_item_t                  result;

  // Configuration registers, written directly by the plain write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HalfPeriodReset;
      max_pulses_q  <= MaxPulsesReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHalfPeriod: half_period_q <= cfg_wdata_i[HalfPeriodWidth-1:0];
        CfgMaxPulses:  max_pulses_q  <= cfg_wdata_i[PulseWidth-1:0];
        default: ;
      endcase
    end
  end

  // An item is consumed in the cycle it is accepted.
  assign step = in_valid_i & ~in_stall_o;

  i2cbc_core #(
    .DelayWidth(DelayWidth)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .item_i       (in_item_i),
    .half_period_i(half_period_q),
    .max_pulses_i (max_pulses_q),
    .result_o     (result)
  );

  i2cbc_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (result),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

@@ design/i2cbc_checker.sv @@
`timescale 1ns / 1ps

module i2cbc_checker
  import i2cbc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // A finished result always shows the bus released and the sequencer idle.
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.finished |->
      !out_item_o.busy_res && out_item_o.scl_release && out_item_o.sda_release)
    else $error("finished result without released bus");

  // When idle, neither line is driven low.
  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.busy_res |->
      out_item_o.scl_release && out_item_o.sda_release)
    else $error("line driven low while idle");

  // Input back-pressure only appears while a result is held at the output.
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // A result held by the sink stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Input back-pressure is released once the output is taken.
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("stall held after output drained");

endmodule

bind i2c_bus_clear_sequencer i2cbc_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the I2C bus-clear sequencer. Every input item is one
// time tick and yields exactly one result item, so the scoreboard predicts one
// result per accepted item and compares results in order.
module tb;
  import i2cbc_pkg::*;

  // Cycles with no handshake on either side before the run is declared hung.
  localparam int unsigned QuietLimit = 2000;

  // Recovery phases of the sequencer, in the order the block walks them.
  typedef enum logic [3:0] {
    SeqIdle,
    SeqRelease,
    SeqLow,
    SeqHigh,
    SeqStop1,
    SeqStop2,
    SeqStop3,
    SeqStop4
  } seq_phase_e;

  // Keeps a private copy of the sequencer state and the two registers, and
  // the results that accepted ticks are still owed.
  class bus_clear_scoreboard;
    logic [HalfPeriodWidth-1:0] half_period;
    logic [PulseWidth-1:0]      max_pulses;
    seq_phase_e                 phase;
    logic [HalfPeriodWidth-1:0] delay;
    logic [PulseWidth-1:0]      pulses;
    logic                       stuck;
    logic                       end_level;
    out_item_t                  pending_results[$];
    int unsigned                mismatches;

    function new();
      half_period = HalfPeriodReset;
      max_pulses  = MaxPulsesReset;
      phase       = SeqIdle;
      delay       = '0;
      pulses      = '0;
      stuck       = 1'b0;
      end_level   = 1'b1;
      mismatches  = 0;
    endfunction

    function void write_reg(logic idx, logic [CfgDataWidth-1:0] data);
      if (idx == CfgHalfPeriod) begin
        half_period = data;
      end else begin
        max_pulses = data[PulseWidth-1:0];
      end
    endfunction

    function bit busy();
      return phase != SeqIdle;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // A new SCL pulse starts with SCL going low; the count saturates.
    function void start_pulse();
      phase = SeqLow;
      if (pulses != {PulseWidth{1'b1}}) begin
        pulses = pulses + PulseWidth'(1);
      end
    endfunction

    // Advances the sequencer by one tick and queues the result it shows.
    function void note_tick(in_item_t it);
      logic [HalfPeriodWidth-1:0] hold;
      out_item_t                  res;
      hold = (half_period == '0) ? 16'd1 : half_period;
      res  = '0;
      if (phase == SeqIdle) begin
        if (it.action) begin
          phase  = SeqRelease;
          delay  = '0;
          pulses = '0;
          stuck  = 1'b0;
        end
      end else begin
        // delay stays below hold, so the increment never wraps.
        delay = delay + HalfPeriodWidth'(1);
        if (delay >= hold) begin
          delay = '0;
          case (phase)
            SeqRelease: begin
              if (it.sda_level) begin
                end_level    = 1'b1;
                phase        = SeqIdle;
                res.finished = 1'b1;
              end else begin
                // SDA held low by a target: clock it out, or go straight to
                // the STOP when no pulses are allowed.
                stuck = 1'b1;
                if (max_pulses != '0) begin
                  start_pulse();
                end else begin
                  phase = SeqStop1;
                end
              end
            end
            SeqLow: phase = SeqHigh;
            SeqHigh: begin
              if (pulses < max_pulses && !it.sda_level) begin
                start_pulse();
              end else begin
                phase = SeqStop1;
              end
            end
            SeqStop1: phase = SeqStop2;
            SeqStop2: phase = SeqStop3;
            SeqStop3: phase = SeqStop4;
            default: begin
              end_level    = it.sda_level;
              phase        = SeqIdle;
              res.finished = 1'b1;
            end
          endcase
        end
      end
      res.scl_release     = !(phase == SeqLow || phase == SeqStop1 || phase == SeqStop2);
      res.sda_release     = !(phase == SeqStop2 || phase == SeqStop3);
      res.busy_res        = (phase != SeqIdle);
      res.was_stuck       = stuck;
      res.pulses_done     = pulses;
      res.sda_free_at_end = end_level;
      pending_results.push_back(res);
    endfunction

    function void compare_field(string field, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
        mismatches++;
        $error("%s: expected %0h, got %0h", field, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("result item arrived with no tick outstanding");
        return;
      end
      want = pending_results.pop_front();
      compare_field("scl_release", 4'(want.scl_release), 4'(got.scl_release));
      compare_field("sda_release", 4'(want.sda_release), 4'(got.sda_release));
      compare_field("busy_res", 4'(want.busy_res), 4'(got.busy_res));
      compare_field("finished", 4'(want.finished), 4'(got.finished));
      compare_field("was_stuck", 4'(want.was_stuck), 4'(got.was_stuck));
      compare_field("pulses_done", want.pulses_done, got.pulses_done);
      compare_field("sda_free_at_end", 4'(want.sda_free_at_end),
                    4'(got.sda_free_at_end));
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic                    cfg_idx = CfgHalfPeriod;
  logic [CfgDataWidth-1:0] cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  in_item_t                in_item = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  out_item_t               out_item;

  // Idling switches, flipped per phase so that some stretches run flat out.
  bit                      send_gaps = 1'b1;
  bit                      sink_stalls = 1'b1;
  int unsigned             stall_left = 0;
  int unsigned             quiet_cycles = 0;

  bus_clear_scoreboard     sb;

  i2c_bus_clear_sequencer DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #2 clk = ~clk;

  // Result side. After each accepted result the sink draws how many cycles it
  // holds stall high before it takes the next one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_item);
        stall_left = sink_stalls ? $urandom_range(0, 18) : 0;
      end else if (stall_left != 0) begin
        stall_left = stall_left - 1;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Hang detection: any handshake on either side resets the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offers one tick after a random gap and returns at the edge that takes it.
  // Valid stays high on return so the next tick can follow back to back.
  task automatic send_tick(input in_item_t it);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_tick(it);
  endtask

  // Stops offering ticks until every owed result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Both registers are written back to back once the block has gone quiet.
  // The upper data bits of the pulse limit are junk the block must ignore.
  task automatic write_config(input logic [HalfPeriodWidth-1:0] hp,
                              input logic [PulseWidth-1:0] mp);
    logic [CfgDataWidth-1:0] mp_word;
    mp_word = CfgDataWidth'($urandom);
    mp_word[PulseWidth-1:0] = mp;
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgHalfPeriod;
    cfg_wdata <= hp;
    @(posedge clk);
    cfg_idx   <= CfgMaxPulses;
    cfg_wdata <= mp_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(CfgHalfPeriod, hp);
    sb.write_reg(CfgMaxPulses, mp_word);
  endtask

  // Keeps ticking until the running sequence completes. low_pct is the chance
  // in percent that SDA reads low on a tick, i.e. how hard the bus is stuck.
  // Occasional starts land mid-sequence and must be ignored.
  task automatic run_out(input int unsigned low_pct);
    in_item_t it;
    while (sb.busy()) begin
      it.action    = ($urandom_range(0, 9) == 0);
      it.sda_level = ($urandom_range(0, 99) >= low_pct);
      send_tick(it);
    end
  endtask

  // One random phase: mostly complete recoveries whose SDA behavior is picked
  // per sequence (free bus, flaky bus, stuck bus), with idle ticks between.
  task automatic random_phase(input logic [HalfPeriodWidth-1:0] hp,
                              input logic [PulseWidth-1:0] mp,
                              input int unsigned n_ticks);
    int unsigned low_pct;
    in_item_t    it;
    write_config(hp, mp);
    send_gaps   = ($urandom_range(0, 3) != 0);
    sink_stalls = ($urandom_range(0, 3) != 0);
    low_pct     = 50;
    repeat (n_ticks) begin
      if (!sb.busy()) begin
        it.action = ($urandom_range(0, 3) == 0);
        if (it.action) begin
          case ($urandom_range(0, 3))
            0: low_pct = 0;
            1: low_pct = 50;
            2: low_pct = 90;
            default: low_pct = 100;
          endcase
        end
      end else begin
        it.action = ($urandom_range(0, 9) == 0);
      end
      it.sda_level = ($urandom_range(0, 99) >= low_pct);
      send_tick(it);
      // Now and then the sender holds off until the block has caught up.
      if ($urandom_range(0, 49) == 0) begin
        drain();
      end
    end
    run_out(low_pct);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings: idle ticks with SDA both ways,
    // then a start that finds the bus free after the release.
    send_tick('{1'b0, 1'b0});
    send_tick('{1'b0, 1'b1});
    send_tick('{1'b1, 1'b1});
    run_out(0);

    // One-tick levels and a limit of two pulses with SDA stuck low: the
    // sequence runs out of pulses, issues the STOP and ends with SDA still low.
    write_config(16'd1, 4'd2);
    send_tick('{1'b1, 1'b0});
    run_out(100);

    // Zero half period acts as one tick; zero pulse limit goes from the
    // stuck check straight into the STOP, then a clean start on a free bus.
    write_config(16'd0, 4'd0);
    send_tick('{1'b1, 1'b0});
    run_out(100);
    send_tick('{1'b1, 1'b1});
    run_out(0);

    random_phase(16'd1, 4'd9, 50);
    random_phase(16'd2, 4'd15, 50);
    random_phase(16'd1, 4'd1, 40);
    random_phase(16'd3, 4'd0, 40);
    random_phase(16'd0, 4'd15, 50);
    random_phase(16'd1, 4'd4, 50);
    random_phase(16'd4, 4'd9, 40);
    random_phase(16'($urandom_range(1, 6)), 4'($urandom_range(0, 15)), 50);
    random_phase(16'd1, 4'd15, 70);

    // A long half period, run without idling: one recovery on a free bus.
    write_config(16'd40, 4'd3);
    send_gaps   = 1'b0;
    sink_stalls = 1'b0;
    send_tick('{1'b1, 1'b1});
    run_out(0);

    drain();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
